FILE: hw/rtl/lcce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcce_pkg
// shared types and codes for the led color crossfade engine
// ----------------------------------------------------------------------------
package lcce_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SET     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_FADE_STEPS = 2'd1;
    localparam logic [1:0] REG_TICK_GAP   = 2'd2;

    // register reset values
    localparam logic [7:0]  FADE_STEPS_RST = 8'd128;
    localparam logic [15:0] TICK_GAP_RST   = 16'd100;

    // mode codes
    localparam logic MODE_STEADY = 1'b0;
    localparam logic MODE_SWEEP  = 1'b1;

    // at most this many leds exist on the strip
    localparam int LED_LIMIT = 16;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  bulb_index;
        logic [23:0] color;
    } in_word_t;

    typedef struct packed {
        logic [3:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } out_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/led_color_crossfade_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_color_crossfade_engine
// per-bulb color store with solid or ping-pong fade toward the complement
// ----------------------------------------------------------------------------
// Holds one 24-bit color per bulb; bulb b drives leds b*LEDS_EACH and up,
// at most sixteen leds in all, and the strip's last led is always sent
// black. A set word stores a color and sends that bulb's leds. In fade
// mode each component shows c + step*(255-2c)/steps (truncated toward zero,
// clamped to 0..255); tick words count toward the tick delay register and,
// when it is reached, every led is sent and the step ping-pongs between 0
// and steps. A restart word clears the step, direction and tick count. One
// word is worked on at a time and in_ready is high only while idle. In
// solid mode each bulb is loaded once and then its leds are sent. In fade
// mode each bulb's three components go one after the other through a
// single 8x8 multiplier and a shared restoring divider (one quotient bit
// a cycle), and then the bulb's leds are sent. Output stalls hold the
// sequencer in its emit state; a finished word may wait in the output
// register while the next input word is taken.
module led_color_crossfade_engine
    import lcce_pkg::*;
#(
    parameter int BULB_COUNT = 4,
    parameter int LEDS_EACH  = 4
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command words
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_word_t              in_word,
    // led words
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_word_t                  out_word,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LED_PRODUCT = BULB_COUNT * LEDS_EACH;
    localparam int LED_TOTAL   = (LED_PRODUCT > LED_LIMIT) ? LED_LIMIT : LED_PRODUCT;
    localparam logic [3:0] LAST_LED = 4'(LED_TOTAL - 1);
    localparam int BULB_W = (BULB_COUNT > 1) ? $clog2(BULB_COUNT) : 1;
    localparam int J_W    = (LEDS_EACH > 1) ? $clog2(LEDS_EACH) : 1;
    localparam logic [J_W-1:0] J_LAST = J_W'(LEDS_EACH - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIX  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [1:0] COMP_BLUE = 2'd2;
    localparam logic [3:0] DIV_LAST  = 4'd15;

    // configuration
    logic        mode_reg,  mode_next;
    logic [7:0]  steps_reg, steps_next;
    logic [15:0] delay_reg, delay_next;

    // fade state
    logic [23:0] colors_reg [BULB_COUNT];
    logic [23:0] colors_next [BULB_COUNT];
    logic [7:0]  step_reg,  step_next;
    logic        back_reg,  back_next;
    logic [15:0] ticks_reg, ticks_next;

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [BULB_W-1:0] bulb_reg,  bulb_next;
    logic [3:0]        led_reg,   led_next;
    logic [J_W-1:0]    j_reg,     j_next;
    logic              all_reg,   all_next;   // full-strip run (tick)
    logic [1:0]        comp_reg,  comp_next;
    logic [3:0]        cnt_reg,   cnt_next;
    logic              out_valid_reg, out_valid_next;

    // datapath payload
    logic [15:0] dq_reg,    dq_next;    // dividend shifting out, quotient in
    logic [7:0]  rem_reg,   rem_next;
    logic        neg_reg,   neg_next;
    logic [23:0] shown_reg, shown_next;
    out_word_t   out_reg,   out_next;

    // combinational helpers
    logic [7:0]  eff_steps;
    logic [23:0] src_color;
    logic [7:0]  comp_byte;
    logic [8:0]  absdiff_w;
    logic [8:0]  div_trial;
    logic signed [17:0] fade_v;
    logic [7:0]  fade_byte;
    logic [15:0] tick_cnt;
    logic [8:0]  step_up;
    logic        last_now;
    logic        accept;
    logic        emit_go;
    logic [23:0] emit_rgb;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assign eff_steps = (steps_reg == 8'd0) ? 8'd1 : steps_reg;
    assign src_color = colors_reg[bulb_reg];

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    comp_byte = src_color[23:16];
            2'd1:    comp_byte = src_color[15:8];
            default: comp_byte = src_color[7:0];
        endcase
    end

    // |255 - 2c|, sign is the top bit of c
    assign absdiff_w = comp_byte[7] ? ({comp_byte, 1'b0} - 9'd255)
                                    : (9'd255 - {comp_byte, 1'b0});

    // one restoring divider step
    assign div_trial = {rem_reg, dq_reg[15]};

    // c -/+ quotient, then clamp
    assign fade_v = neg_reg ? ($signed({10'b0, comp_byte}) - $signed({2'b0, dq_reg}))
                            : ($signed({10'b0, comp_byte}) + $signed({2'b0, dq_reg}));

    always_comb
    begin
        priority if (fade_v < 18'sd0)
            fade_byte = 8'd0;
        else if (fade_v > 18'sd255)
            fade_byte = 8'd255;
        else
            fade_byte = fade_v[7:0];
    end

    // saturating tick count
    assign tick_cnt = (ticks_reg == 16'hFFFF) ? ticks_reg : (ticks_reg + 16'd1);
    assign step_up  = {1'b0, step_reg} + 9'd1;

    // final led of this run: end of strip, or end of the bulb for a set word
    assign last_now = (led_reg == LAST_LED) || (!all_reg && (j_reg == J_LAST));
    assign emit_go  = !out_valid_reg || out_ready;
    assign emit_rgb = (led_reg == LAST_LED) ? 24'd0 : shown_reg;

    always_comb
    begin
        mode_next      = mode_reg;
        steps_next     = steps_reg;
        delay_next     = delay_reg;
        colors_next    = colors_reg;
        step_next      = step_reg;
        back_next      = back_reg;
        ticks_next     = ticks_reg;
        state_next     = state_reg;
        bulb_next      = bulb_reg;
        led_next       = led_reg;
        j_next         = j_reg;
        all_next       = all_reg;
        comp_next      = comp_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        shown_next     = shown_reg;
        out_next       = out_reg;

        // the user writes configuration only while idle; the block does not enforce it
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:       mode_next  = cfg_data[0];
                REG_FADE_STEPS: steps_next = cfg_data[7:0];
                REG_TICK_GAP:   delay_next = cfg_data;
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_word.command)
                        CMD_TICK:
                        begin
                            if (mode_reg == MODE_SWEEP)
                            begin
                                if (tick_cnt < delay_reg)
                                    ticks_next = tick_cnt;
                                else
                                begin
                                    // fade update: walk the whole strip
                                    ticks_next = 16'd0;
                                    bulb_next  = '0;
                                    led_next   = 4'd0;
                                    j_next     = '0;
                                    all_next   = 1'b1;
                                    state_next = ST_LOAD;
                                end
                            end
                        end
                        CMD_SET:
                        begin
                            if (32'(in_word.bulb_index) < BULB_COUNT)
                            begin
                                colors_next[BULB_W'(in_word.bulb_index)] = in_word.color;
                                // a bulb past the sixteenth led sends nothing
                                if (32'(in_word.bulb_index) * LEDS_EACH < LED_TOTAL)
                                begin
                                    bulb_next  = BULB_W'(in_word.bulb_index);
                                    led_next   = 4'(32'(in_word.bulb_index) * LEDS_EACH);
                                    j_next     = '0;
                                    all_next   = 1'b0;
                                    state_next = ST_LOAD;
                                end
                            end
                        end
                        CMD_RESTART:
                        begin
                            step_next  = 8'd0;
                            back_next  = 1'b0;
                            ticks_next = 16'd0;
                        end
                        default: ;
                    endcase
                end
            end

            ST_LOAD:
            begin
                if (mode_reg == MODE_STEADY)
                begin
                    shown_next = src_color;
                    state_next = ST_EMIT;
                end
                else
                begin
                    comp_next  = 2'd0;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                dq_next    = step_reg * absdiff_w[7:0];
                neg_next   = comp_byte[7];
                rem_next   = 8'd0;
                cnt_next   = 4'd0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_trial >= {1'b0, eff_steps})
                begin
                    rem_next = 8'(div_trial - {1'b0, eff_steps});
                    dq_next  = {dq_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = div_trial[7:0];
                    dq_next  = {dq_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_FIX;
            end

            ST_FIX:
            begin
                unique case (comp_reg)
                    2'd0:    shown_next[23:16] = fade_byte;
                    2'd1:    shown_next[15:8]  = fade_byte;
                    default: shown_next[7:0]   = fade_byte;
                endcase
                if (comp_reg == COMP_BLUE)
                    state_next = ST_EMIT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end

            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next      = 1'b1;
                    out_next.led_index  = led_reg;
                    out_next.red        = emit_rgb[23:16];
                    out_next.green      = emit_rgb[15:8];
                    out_next.blue       = emit_rgb[7:0];
                    out_next.last       = last_now;
                    if (last_now)
                    begin
                        state_next = ST_IDLE;
                        // step moves only after a full fade update
                        if (all_reg)
                        begin
                            if (back_reg)
                            begin
                                if (step_reg <= 8'd1)
                                begin
                                    step_next = 8'd0;
                                    back_next = 1'b0;
                                end
                                else
                                    step_next = step_reg - 8'd1;
                            end
                            else
                            begin
                                if (step_up >= {1'b0, eff_steps})
                                begin
                                    step_next = eff_steps;
                                    back_next = 1'b1;
                                end
                                else
                                    step_next = step_up[7:0];
                            end
                        end
                    end
                    else if (j_reg == J_LAST)
                    begin
                        // next bulb of the strip
                        bulb_next  = BULB_W'(32'(bulb_reg) + 1);
                        led_next   = led_reg + 4'd1;
                        j_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        led_next = led_reg + 4'd1;
                        j_next   = J_W'(32'(j_reg) + 1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STEADY;
            steps_reg     <= FADE_STEPS_RST;
            delay_reg     <= TICK_GAP_RST;
            for (int i = 0; i < BULB_COUNT; i++)
            begin
                colors_reg[i] <= 24'd0;
            end
            step_reg      <= 8'd0;
            back_reg      <= 1'b0;
            ticks_reg     <= 16'd0;
            state_reg     <= ST_IDLE;
            bulb_reg      <= '0;
            led_reg       <= 4'd0;
            j_reg         <= '0;
            all_reg       <= 1'b0;
            comp_reg      <= 2'd0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            steps_reg     <= steps_next;
            delay_reg     <= delay_next;
            colors_reg    <= colors_next;
            step_reg      <= step_next;
            back_reg      <= back_next;
            ticks_reg     <= ticks_next;
            state_reg     <= state_next;
            bulb_reg      <= bulb_next;
            led_reg       <= led_next;
            j_reg         <= j_next;
            all_reg       <= all_next;
            comp_reg      <= comp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        shown_reg <= shown_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

FILE: verif/led_color_crossfade_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_color_crossfade_engine_test
// self-checking bench: command words go in through a randomly gapped driver,
// every led word coming out is compared field by field with a shadow of the
// bulb store, fade step and tick counter kept inside the bench
// ----------------------------------------------------------------------------
module led_color_crossfade_engine_test
    import lcce_pkg::*;
;

    // geometry of the instance under test
    localparam int BULBS     = 4;
    localparam int BULB_LEDS = 4;
    localparam int LED_TOTAL = (BULBS * BULB_LEDS > LED_LIMIT) ?
                               LED_LIMIT : BULBS * BULB_LEDS;

    // command code the block has no use for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // cycles to let a word that sends nothing finish before touching registers
    localparam int SETTLE_CYCLES = 300;
    // cycles with no handshake on either side before giving up
    localparam int QUIET_LIMIT   = 5000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // command words waiting for the driver, led words waiting for the block
    in_word_t  words_to_send[$];
    out_word_t leds_due[$];

    // shadow of the block's state and registers
    logic [23:0] bulb_rgb[BULBS];
    logic [7:0]  fade_pos;
    logic        fading_back;
    logic [15:0] tick_count;
    logic        mode_now;
    logic [7:0]  steps_now;
    logic [15:0] delay_now;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    // set while a stretch without any idling is wanted
    bit no_gaps        = 1'b0;

    led_color_crossfade_engine #(
        .BULB_COUNT (BULBS),
        .LEDS_EACH  (BULB_LEDS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------------

    // one color component at the current fade step; the division truncates
    // toward zero and a step past the step count can push the value outside
    // the byte, so it is clamped
    function automatic logic [7:0] fade_component(input logic [7:0] c);
        int divisor;
        int span;
        int level;
        divisor = (steps_now == 8'd0) ? 1 : int'(steps_now);
        span    = 255 - 2 * int'(c);
        level   = int'(c) + (int'(fade_pos) * span) / divisor;
        if (level < 0)
            level = 0;
        if (level > 255)
            level = 255;
        return level[7:0];
    endfunction

    function automatic logic [23:0] shown_rgb(input logic [23:0] c);
        if (mode_now == MODE_STEADY)
            return c;
        return {fade_component(c[23:16]), fade_component(c[15:8]),
                fade_component(c[7:0])};
    endfunction

    // the strip's last led always goes out black
    task automatic push_led(input int led, input logic [23:0] rgb, input bit last);
        out_word_t w;
        if (led == LED_TOTAL - 1)
            rgb = '0;
        w.led_index = led[3:0];
        w.red       = rgb[23:16];
        w.green     = rgb[15:8];
        w.blue      = rgb[7:0];
        w.last      = last;
        leds_due.push_back(w);
    endtask

    // ping-pong between 0 and the step count; zero steps acts as one
    task automatic advance_fade();
        int top;
        top = (steps_now == 8'd0) ? 1 : int'(steps_now);
        if (fading_back)
        begin
            if (fade_pos <= 8'd1)
            begin
                fade_pos    = 8'd0;
                fading_back = 1'b0;
            end
            else
                fade_pos = fade_pos - 8'd1;
        end
        else if (int'(fade_pos) + 1 >= top)
        begin
            fade_pos    = top[7:0];
            fading_back = 1'b1;
        end
        else
            fade_pos = fade_pos + 8'd1;
    endtask

    // led words that one accepted command word must produce
    task automatic predict_leds(input in_word_t w);
        logic [16:0] count;
        int          first;
        int          stop;
        case (w.command)
            CMD_TICK:
                // ticks only count in fade mode; the counter saturates
                if (mode_now == MODE_SWEEP)
                begin
                    count = (tick_count == 16'hFFFF) ? 17'h0FFFF : tick_count + 17'd1;
                    if (count < {1'b0, delay_now})
                        tick_count = count[15:0];
                    else
                    begin
                        tick_count = '0;
                        for (int led = 0; led < LED_TOTAL; led++)
                            push_led(led, shown_rgb(bulb_rgb[led / BULB_LEDS]),
                                     led == LED_TOTAL - 1);
                        advance_fade();
                    end
                end
            CMD_SET:
                // bulbs past the end are ignored
                if (int'(w.bulb_index) < BULBS)
                begin
                    bulb_rgb[w.bulb_index] = w.color;
                    first = int'(w.bulb_index) * BULB_LEDS;
                    stop  = (first + BULB_LEDS > LED_TOTAL) ?
                            LED_TOTAL : first + BULB_LEDS;
                    for (int led = first; led < stop; led++)
                        push_led(led, shown_rgb(w.color), led == stop - 1);
                end
            CMD_RESTART:
            begin
                fade_pos    = '0;
                fading_back = 1'b0;
                tick_count  = '0;
            end
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_led(input out_word_t got);
        out_word_t want;
        if (leds_due.size() == 0)
        begin
            report_mismatch("led word with none due, led", got.led_index, -1);
            return;
        end
        want = leds_due.pop_front();
        if (got.led_index !== want.led_index)
            report_mismatch("led_index", got.led_index, want.led_index);
        if (got.red !== want.red)
            report_mismatch($sformatf("red of led %0d", want.led_index), got.red, want.red);
        if (got.green !== want.green)
            report_mismatch($sformatf("green of led %0d", want.led_index),
                            got.green, want.green);
        if (got.blue !== want.blue)
            report_mismatch($sformatf("blue of led %0d", want.led_index), got.blue, want.blue);
        if (got.last !== want.last)
            report_mismatch($sformatf("last of led %0d", want.led_index), got.last, want.last);
    endtask

    // ------------------------------------------------------------------------
    // driver: one pending command word at a time, held until taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            // about one cycle in ten the sender holds back
            if (words_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= 10))
            begin
                in_valid <= 1'b1;
                in_word  <= words_to_send.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on every accepted command word, check every led word
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            // prediction first, a led word never leaves in the cycle its
            // command word goes in
            if (in_valid && in_ready)
                predict_leds(in_word);
            if (out_valid && out_ready)
                check_led(out_word);
            out_ready <= no_gaps || $urandom_range(99) >= 10;
        end
    end

    // watchdog on cycles in which no word moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[led_color_crossfade_engine] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // registers change only while idle, so the shadow copy is updated here
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_MODE:       mode_now  = value[0];
            REG_FADE_STEPS: steps_now = value[7:0];
            REG_TICK_GAP:   delay_now = value;
            default:        ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic mode, input logic [7:0] steps,
                             input logic [15:0] delay);
        write_reg(REG_MODE, {15'd0, mode});
        write_reg(REG_FADE_STEPS, {8'd0, steps});
        write_reg(REG_TICK_GAP, delay);
    endtask

    task automatic queue_word(input logic [1:0] cmd, input logic [1:0] bulb,
                              input logic [23:0] color);
        in_word_t w;
        w.command    = cmd;
        w.bulb_index = bulb;
        w.color      = color;
        words_to_send.push_back(w);
    endtask

    // all words taken, all led words back, then time for a word that sends
    // nothing to finish inside the block
    task automatic settle();
        while (words_to_send.size() != 0 || in_valid || leds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // components lean toward the extremes now and then
    function automatic logic [7:0] random_component();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly ticks, which drive the fade forward, and sets, with some restarts
    // and unused codes thrown in
    function automatic in_word_t random_word();
        in_word_t w;
        int       pick;
        pick         = $urandom_range(99);
        w.command    = (pick < 55) ? CMD_TICK :
                       (pick < 85) ? CMD_SET :
                       (pick < 93) ? CMD_RESTART : CMD_UNUSED;
        w.bulb_index = 2'($urandom_range(3));
        w.color      = {random_component(), random_component(), random_component()};
        return w;
    endfunction

    task automatic random_phase(input logic mode, input logic [7:0] steps,
                                input logic [15:0] delay, input int target);
        int       counted;
        in_word_t w;
        counted = 0;
        write_all(mode, steps, delay);
        while (counted < target)
        begin
            w = random_word();
            words_to_send.push_back(w);
            counted++;
        end
        settle();
    endtask

    initial
    begin
        for (int b = 0; b < BULBS; b++)
            bulb_rgb[b] = '0;
        fade_pos    = '0;
        fading_back = 1'b0;
        tick_count  = '0;
        mode_now    = MODE_STEADY;
        steps_now   = FADE_STEPS_RST;
        delay_now   = TICK_GAP_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // solid mode at reset settings: color extremes and two mixed colors on the bulbs, the
        // last bulb shows the black last led, ticks and unused codes do nothing
        queue_word(CMD_SET, 2'd0, 24'h000000);
        queue_word(CMD_SET, 2'd1, 24'hFFFFFF);
        queue_word(CMD_SET, 2'd2, 24'h123456);
        queue_word(CMD_SET, 2'd3, 24'hA5C3F0);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        queue_word(CMD_RESTART, 2'd3, 24'hFFFFFF);
        queue_word(CMD_UNUSED, 2'd3, 24'hFFFFFF);
        settle();

        // single step fade with no delay: every tick updates the whole strip
        write_all(MODE_SWEEP, 8'd1, 16'd0);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        queue_word(CMD_SET, 2'd1, 24'h00FF80);
        settle();

        // walk the step up to four out of eight
        write_reg(REG_FADE_STEPS, 16'd8);
        queue_word(CMD_RESTART, 2'd0, 24'h000000);
        repeat (4) queue_word(CMD_TICK, 2'd0, 24'h000000);
        settle();

        // step now sits past the step count, components clamp
        write_all(MODE_SWEEP, 8'd2, 16'd2);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        settle();

        // zero steps acts as one; the tick count left above a lowered delay
        // fires on the next tick
        write_all(MODE_SWEEP, 8'd0, 16'd5);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        settle();
        write_reg(REG_TICK_GAP, 16'd1);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        settle();

        // largest step count and delay: ticks only count
        write_all(MODE_SWEEP, 8'd255, 16'hFFFF);
        queue_word(CMD_TICK, 2'd0, 24'h000000);
        queue_word(CMD_RESTART, 2'd0, 24'h000000);
        queue_word(CMD_SET, 2'd2, 24'hFF00FF);
        settle();

        // random part over several register settings
        random_phase(MODE_SWEEP, 8'd3, 16'd1, 68);
        random_phase(MODE_STEADY, FADE_STEPS_RST, 16'd0, 68);
        no_gaps = 1'b1;
        random_phase(MODE_SWEEP, 8'd255, 16'd0, 68);
        no_gaps = 1'b0;
        random_phase(MODE_SWEEP, 8'($urandom_range(1, 16)), 16'($urandom_range(4)), 68);
        random_phase(MODE_SWEEP, 8'($urandom_range(1, 255)), 16'($urandom_range(2)), 68);
        random_phase(MODE_SWEEP, 8'd0, 16'd2, 66);

        if (mismatch_count == 0)
            $display("[led_color_crossfade_engine] OK");
        else
            $display("[led_color_crossfade_engine] ERROR");
        $finish;
    end

endmodule
